// File: rtl/bre_pkg.sv
// Shared types and constants for the breathe/rainbow LED engine.
// No dependencies; every file but bre_ifs imports this package.
`default_nettype none

package bre_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [7:0]  LVL_MAX       = 8'd255;
    localparam logic [15:0] HOLD_MS_RESET = 16'd2000;
    localparam logic [15:0] MS_MAX        = 16'hFFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EFFECT_MODE = 2'd0,
        CFG_BREATH_STEP = 2'd1,
        CFG_COLOR_STEP  = 2'd2,
        CFG_HOLD_MS     = 2'd3
    } cfg_idx_t;

    typedef enum logic {
        OP_TICK    = 1'b0,
        OP_REFRESH = 1'b1
    } opcode_t;

    typedef enum logic {
        MODE_FIXED   = 1'b0,
        MODE_RAINBOW = 1'b1
    } mode_t;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } color_t;

    // One refresh as handed from the breath control to the scaling lanes
    typedef struct packed {
        color_t     color;
        logic [7:0] lvl;
        logic       done;
    } step_t;

endpackage

`default_nettype wire

// File: rtl/bre_ifs.sv
// Valid/ready channel interfaces for input items and result items.
// Depends on nothing; used by the top level.
`default_nettype none

interface bre_item_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, opcode, red, green, blue, input ready);
    modport sink   (input valid, opcode, red, green, blue, output ready);
endinterface

interface bre_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       breath_done;

    modport source (output valid, out_red, out_green, out_blue, breath_done, input ready);
    modport sink   (input valid, out_red, out_green, out_blue, breath_done, output ready);
endinterface

`default_nettype wire

// File: rtl/bre_lane.sv
// One color-component scaling lane: registered (lvl*c+127)/255.
// Depends on bre_pkg.
`default_nettype none

module bre_lane
    import bre_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       load,
    input  wire logic [7:0] comp,
    input  wire logic [7:0] lvl,
    output logic      [7:0] scaled
);

    logic [15:0] prod;
    logic [15:0] biased;
    logic [16:0] quo_sum;
    logic [7:0]  scaled_reg;
    logic [7:0]  scaled_next;

    // x/255 == (x + (x>>8) + 1) >> 8 for x below 65535
    always_comb
    begin
        prod        = 16'(comp) * 16'(lvl);
        biased      = prod + 16'd127;
        quo_sum     = 17'(biased) + 17'(biased[15:8]) + 17'd1;
        scaled_next = quo_sum[15:8];
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            scaled_reg <= scaled_next;
        end
    end

    assign scaled = scaled_reg;

endmodule

`default_nettype wire

// File: rtl/bre_ctrl.sv
// Breath control: config registers, brightness ramp, hold counter, color wheel.
// Depends on bre_pkg. Produces one step_t per refresh transfer.
`default_nettype none

module bre_ctrl
    import bre_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  accept,
    input  wire logic                  opcode,
    input  wire color_t                in_color,
    output step_t                      step
);

    logic        mode_reg,  mode_next;
    logic [7:0]  bstep_reg, bstep_next;
    logic [7:0]  cstep_reg, cstep_next;
    logic [15:0] hold_reg,  hold_next;

    logic        rising_reg,  rising_next;
    logic [7:0]  lvl_reg,     lvl_next;
    logic [15:0] elapsed_reg, elapsed_next;
    color_t      wheel_reg,   wheel_next;

    logic        is_tick;
    logic        is_ref;
    logic        holding;
    logic [7:0]  bstep_eff;
    logic [7:0]  cstep_eff;
    logic [8:0]  up_sum;
    logic [8:0]  dn_diff;
    logic [7:0]  ramp_lvl;
    logic        done;
    color_t      wheel_norm;

    // Drain a into b; on wrap, a goes to 0, b takes the wrapped value and c its complement to 255
    function automatic logic [23:0] wheel_seg(input logic [7:0] a, input logic [7:0] b,
                                              input logic [7:0] c, input logic [7:0] s);
        logic [7:0] t;
        t = a - s;
        if (t > a)
        begin
            wheel_seg = {8'd0, t, LVL_MAX - t};
        end
        else
        begin
            wheel_seg = {t, b + s, c};
        end
    endfunction

    always_comb
    begin
        mode_next  = mode_reg;
        bstep_next = bstep_reg;
        cstep_next = cstep_reg;
        hold_next  = hold_reg;
        if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_idx))
                CFG_EFFECT_MODE: mode_next  = cfg_data[0];
                CFG_BREATH_STEP: bstep_next = cfg_data[7:0];
                CFG_COLOR_STEP:  cstep_next = cfg_data[7:0];
                CFG_HOLD_MS:     hold_next  = cfg_data;
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        is_tick   = accept && (opcode == OP_TICK);
        is_ref    = accept && (opcode == OP_REFRESH);
        holding   = (lvl_reg == 8'd0) && (elapsed_reg < hold_reg);
        bstep_eff = (bstep_reg == 8'd0) ? 8'd1 : bstep_reg;
        cstep_eff = (cstep_reg == 8'd0) ? 8'd1 : cstep_reg;

        up_sum  = 9'(lvl_reg) + 9'(bstep_eff);
        dn_diff = 9'(lvl_reg) - 9'(bstep_eff);
        if (rising_reg)
        begin
            ramp_lvl = up_sum[8] ? LVL_MAX : up_sum[7:0];
        end
        else
        begin
            ramp_lvl = dn_diff[8] ? 8'd0 : dn_diff[7:0];
        end
        done = is_ref && !holding && (ramp_lvl == 8'd0);

        // Any color with all three components lit restarts at pure red
        if ((wheel_reg.r != 8'd0) && (wheel_reg.g != 8'd0) && (wheel_reg.b != 8'd0))
        begin
            wheel_norm = '{r: LVL_MAX, g: 8'd0, b: 8'd0};
        end
        else
        begin
            wheel_norm = wheel_reg;
        end

        lvl_next     = lvl_reg;
        rising_next  = rising_reg;
        elapsed_next = elapsed_reg;
        wheel_next   = wheel_reg;

        if (is_tick && (elapsed_reg != MS_MAX))
        begin
            elapsed_next = elapsed_reg + 16'd1;
        end

        if (is_ref && !holding)
        begin
            lvl_next = ramp_lvl;
            if (rising_reg)
            begin
                rising_next = (ramp_lvl != LVL_MAX);
            end
        end

        if (done)
        begin
            elapsed_next = 16'd0;
            rising_next  = 1'b1;
            if (mode_reg == MODE_RAINBOW)
            begin
                if ((wheel_norm.g != LVL_MAX) && (wheel_norm.b == 8'd0))
                begin
                    {wheel_next.r, wheel_next.g, wheel_next.b} =
                        wheel_seg(wheel_norm.r, wheel_norm.g, wheel_norm.b, cstep_eff);
                end
                else if (wheel_norm.g != 8'd0)
                begin
                    {wheel_next.g, wheel_next.b, wheel_next.r} =
                        wheel_seg(wheel_norm.g, wheel_norm.b, wheel_norm.r, cstep_eff);
                end
                else
                begin
                    {wheel_next.b, wheel_next.r, wheel_next.g} =
                        wheel_seg(wheel_norm.b, wheel_norm.r, wheel_norm.g, cstep_eff);
                end
            end
        end

        step.color = (mode_reg == MODE_RAINBOW) ? wheel_reg : in_color;
        step.lvl   = lvl_reg;
        step.done  = done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_FIXED;
            bstep_reg   <= 8'd1;
            cstep_reg   <= 8'd1;
            hold_reg    <= HOLD_MS_RESET;
            rising_reg  <= 1'b1;
            lvl_reg     <= 8'd0;
            elapsed_reg <= 16'd0;
            wheel_reg   <= '{r: LVL_MAX, g: 8'd0, b: 8'd0};
        end
        else
        begin
            mode_reg    <= mode_next;
            bstep_reg   <= bstep_next;
            cstep_reg   <= cstep_next;
            hold_reg    <= hold_next;
            rising_reg  <= rising_next;
            lvl_reg     <= lvl_next;
            elapsed_reg <= elapsed_next;
            wheel_reg   <= wheel_next;
        end
    end

    // A level of full scale always means the ramp is on its way down
    a_no_rising_at_max: assert property (@(posedge clk) disable iff (!rst_n)
        rising_reg |-> (lvl_reg != LVL_MAX))
        else $error("brightness at max while still rising");

    a_done_resets: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (lvl_reg == 8'd0) && rising_reg && (elapsed_reg == 16'd0))
        else $error("completed breath did not restart the ramp");

    a_hold_keeps_level: assert property (@(posedge clk) disable iff (!rst_n)
        (is_ref && holding) |=> (lvl_reg == 8'd0))
        else $error("level moved during dark hold");

endmodule

`default_nettype wire

// File: rtl/breathe_rainbow_engine_top.sv
// Breathing LED engine, top level: input stage, three scaling lanes, result merge.
// Depends on bre_pkg, bre_ifs, bre_ctrl, bre_lane.
//
// Takes one item per clock while item.ready is high. A tick transfer bumps the
// millisecond counter and yields no result. A refresh transfer updates the breath
// state in the cycle it is taken and yields one result, held first in the step
// register and then in the red/green/blue scaling lanes (8x8 multiply and a
// divide-by-255 done as shift-add), whose registers form the output stage.
// item.ready drops only when both stages are full and result.ready is low.
// Configuration writes take effect on the next clock and should be made idle.
`default_nettype none

module breathe_rainbow_engine_top
    import bre_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    bre_item_if.sink                   item,
    bre_result_if.source               result
);

    step_t  ctrl_step;
    step_t  s1_reg;
    logic   s1_valid_reg, s1_valid_next;
    logic   res_valid_reg, res_valid_next;
    logic   done_reg;
    logic   res_load;
    logic   s1_free;
    logic   accept;
    color_t in_color;

    assign in_color = '{r: item.red, g: item.green, b: item.blue};

    always_comb
    begin
        res_load       = s1_valid_reg && (!res_valid_reg || result.ready);
        s1_free        = !s1_valid_reg || res_load;
        accept         = item.valid && s1_free;
        s1_valid_next  = s1_free ? (accept && (item.opcode == OP_REFRESH)) : s1_valid_reg;
        res_valid_next = res_load ? 1'b1 : (res_valid_reg && !result.ready);
    end

    assign item.ready = s1_free;

    bre_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .accept   (accept),
        .opcode   (item.opcode),
        .in_color (in_color),
        .step     (ctrl_step)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_free)
        begin
            s1_reg <= ctrl_step;
        end
        if (res_load)
        begin
            done_reg <= s1_reg.done;
        end
    end

    bre_lane u_lane_red (
        .clk    (clk),
        .load   (res_load),
        .comp   (s1_reg.color.r),
        .lvl    (s1_reg.lvl),
        .scaled (result.out_red)
    );

    bre_lane u_lane_green (
        .clk    (clk),
        .load   (res_load),
        .comp   (s1_reg.color.g),
        .lvl    (s1_reg.lvl),
        .scaled (result.out_green)
    );

    bre_lane u_lane_blue (
        .clk    (clk),
        .load   (res_load),
        .comp   (s1_reg.color.b),
        .lvl    (s1_reg.lvl),
        .scaled (result.out_blue)
    );

    assign result.valid       = res_valid_reg;
    assign result.breath_done = done_reg;

    a_res_from_stage1: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(s1_valid_reg))
        else $error("result appeared without a pending step");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> item.ready)
        else $error("input stalled with empty step stage");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !item.ready |-> (s1_valid_reg && res_valid_reg && !result.ready))
        else $error("input stalled while pipeline could advance");

endmodule

`default_nettype wire

// File: test/breath_checker.sv
// Watches the item, result and register-write ports of the breathing engine and
// predicts each refresh result (scaled color and breath-done flag). Depends on bre_pkg, bre_ifs.
`timescale 1ns / 1ps

module breath_checker
    import bre_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    bre_item_if                        item,
    bre_result_if                      result,
    output int unsigned                mismatches,
    output int unsigned                results_owed
);

    typedef struct packed {
        color_t color;
        logic   done;
    } pixel_t;

    // register copies
    mode_t       effect_mode;
    logic [7:0]  breath_step;
    logic [7:0]  color_step;
    logic [15:0] hold_ms;

    // breath state
    logic [7:0]  level;
    logic        rising;
    logic [15:0] elapsed_ms;
    color_t      wheel;

    pixel_t      owed_pixels[$];

    task automatic flag_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
        mismatches++;
        $display("%0t: %s mismatch: got %0d, expected %0d", $time, what, got, want);
    endtask

    function automatic logic [7:0] scaled_channel(input logic [7:0] c, input logic [7:0] lvl);
        logic [15:0] p;
        p = lvl * c + 16'd127;
        return 8'(p / 16'd255);
    endfunction

    // Move s from a into b; when a runs out the hue passes on to b and c.
    function automatic void drain_into(inout logic [7:0] a, inout logic [7:0] b,
                                       inout logic [7:0] c, input logic [7:0] s);
        logic [7:0] t;
        t = a - s;
        if (t > a)
        begin
            a = 8'd0;
            b = t;
            c = LVL_MAX - t;
        end
        else
        begin
            a = t;
            b = b + s;
        end
    endfunction

    function automatic void advance_wheel();
        logic [7:0] s;
        s = (color_step == 8'd0) ? 8'd1 : color_step;
        if (wheel.r != 8'd0 && wheel.g != 8'd0 && wheel.b != 8'd0)
            wheel = color_t'{LVL_MAX, 8'd0, 8'd0};
        if (wheel.g < LVL_MAX && wheel.b == 8'd0)
            drain_into(wheel.r, wheel.g, wheel.b, s);
        else if (wheel.g != 8'd0)
            drain_into(wheel.g, wheel.b, wheel.r, s);
        else
            drain_into(wheel.b, wheel.r, wheel.g, s);
    endfunction

    // Output uses the level from before this refresh's step.
    function automatic pixel_t take_refresh(input color_t in_color);
        color_t     src;
        pixel_t     px;
        logic [7:0] step;
        logic [7:0] nxt;
        src = (effect_mode == MODE_RAINBOW) ? wheel : in_color;
        px.color.r = scaled_channel(src.r, level);
        px.color.g = scaled_channel(src.g, level);
        px.color.b = scaled_channel(src.b, level);
        px.done    = 1'b0;
        if (!(level == 8'd0 && elapsed_ms < hold_ms))
        begin
            step = (breath_step == 8'd0) ? 8'd1 : breath_step;
            if (rising)
            begin
                nxt = level + step;
                if (nxt < level)
                    nxt = LVL_MAX;
                rising = (nxt != LVL_MAX);
            end
            else
            begin
                nxt = level - step;
                if (nxt > level)
                    nxt = 8'd0;
            end
            level = nxt;
            if (nxt == 8'd0)
            begin
                elapsed_ms = 16'd0;
                rising     = 1'b1;
                px.done    = 1'b1;
                if (effect_mode == MODE_RAINBOW)
                    advance_wheel();
            end
        end
        return px;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pixel_t want;
        if (!rst_n)
        begin
            effect_mode  = MODE_FIXED;
            breath_step  = 8'd1;
            color_step   = 8'd1;
            hold_ms      = HOLD_MS_RESET;
            level        = 8'd0;
            rising       = 1'b1;
            elapsed_ms   = 16'd0;
            wheel        = color_t'{LVL_MAX, 8'd0, 8'd0};
            owed_pixels.delete();
            results_owed = 0;
            mismatches   = 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                if (owed_pixels.size() == 0)
                    flag_mismatch("unexpected result", 1, 0);
                else
                begin
                    want = owed_pixels.pop_front();
                    if (result.out_red != want.color.r)
                        flag_mismatch("out_red", result.out_red, want.color.r);
                    if (result.out_green != want.color.g)
                        flag_mismatch("out_green", result.out_green, want.color.g);
                    if (result.out_blue != want.color.b)
                        flag_mismatch("out_blue", result.out_blue, want.color.b);
                    if (result.breath_done != want.done)
                        flag_mismatch("breath_done", result.breath_done, want.done);
                end
            end

            if (item.valid && item.ready)
            begin
                if (item.opcode == OP_TICK)
                begin
                    if (elapsed_ms != MS_MAX)
                        elapsed_ms++;
                end
                else
                    owed_pixels.push_back(
                        take_refresh(color_t'{item.red, item.green, item.blue}));
            end

            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_idx))
                    CFG_EFFECT_MODE: effect_mode = mode_t'(cfg_data[0]);
                    CFG_BREATH_STEP: breath_step = cfg_data[7:0];
                    CFG_COLOR_STEP:  color_step  = cfg_data[7:0];
                    CFG_HOLD_MS:     hold_ms     = cfg_data;
                    default:         ;
                endcase
            end

            results_owed = owed_pixels.size();
        end
    end

endmodule

// File: test/testbench.sv
// Top of the breathing engine testbench: clock, reset, stimulus, register programming
// and the verdict. Depends on bre_pkg, bre_ifs, the engine RTL and breath_checker.
`timescale 1ns / 1ps

module testbench;
    import bre_pkg::*;

    localparam int          HALF_PERIOD    = 2;
    localparam int          RESET_CYCLES   = 7;
    localparam int unsigned WATCHDOG_LIMIT = 5000;
    localparam int          DRAIN_CYCLES   = 8;
    localparam int          BATCH_ITEMS    = 150;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    cfg_idx_t              cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned mismatches;
    int unsigned results_owed;
    int unsigned quiet_cycles;

    bre_item_if   item();
    bre_result_if result();

    breathe_rainbow_engine_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .item     (item),
        .result   (result)
    );

    breath_checker chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_idx      (cfg_idx),
        .cfg_data     (cfg_data),
        .item         (item),
        .result       (result),
        .mismatches   (mismatches),
        .results_owed (results_owed)
    );

    always #(HALF_PERIOD) clk = ~clk;

    always @(negedge clk)
        result.ready <= ($urandom_range(99) >= recv_idle_pct);

    // no transfer on either channel for too long means the block is stuck
    always @(posedge clk)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else
        begin
            if ((item.valid && item.ready) || (result.valid && result.ready))
                quiet_cycles <= 0;
            else if (quiet_cycles + 1 >= WATCHDOG_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic color_t random_color();
        logic [7:0] comp[3];
        foreach (comp[i])
        begin
            case ($urandom_range(9))
                0:       comp[i] = 8'd0;
                1:       comp[i] = 8'd255;
                default: comp[i] = 8'($urandom_range(255));
            endcase
        end
        return color_t'{comp[0], comp[1], comp[2]};
    endfunction

    // Called and returns at a falling edge; valid stays high between back-to-back items.
    task automatic send_item(input opcode_t op, input color_t c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item.valid <= 1'b0;
            @(negedge clk);
        end
        item.valid  <= 1'b1;
        item.opcode <= op;
        item.red    <= c.r;
        item.green  <= c.g;
        item.blue   <= c.b;
        @(posedge clk);
        while (!item.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_tick();
        send_item(OP_TICK, random_color());
    endtask

    task automatic send_refresh(input color_t c);
        send_item(OP_REFRESH, c);
    endtask

    task automatic drain_results();
        item.valid <= 1'b0;
        while (results_owed != 0)
            @(negedge clk);
    endtask

    task automatic quiesce();
        drain_results();
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic program_effect(input mode_t mode, input logic [7:0] bstep,
                                  input logic [7:0] cstep, input logic [15:0] hold);
        quiesce();
        write_reg(CFG_EFFECT_MODE, CFG_DATA_W'(mode));
        write_reg(CFG_BREATH_STEP, CFG_DATA_W'(bstep));
        write_reg(CFG_COLOR_STEP, CFG_DATA_W'(cstep));
        write_reg(CFG_HOLD_MS, hold);
        @(negedge clk);
    endtask

    task automatic program_random_effect();
        program_effect(mode_t'($urandom_range(1)), 8'($urandom_range(255)),
                       8'($urandom_range(255)), 16'($urandom_range(6)));
    endtask

    // Mostly refreshes so breaths complete; ticks keep the short hold moving.
    task automatic random_batch(input int n);
        repeat (n)
        begin
            if ($urandom_range(99) < 75)
                send_refresh(random_color());
            else
                send_tick();
            if ($urandom_range(149) == 0)
                drain_results();
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_idx       = CFG_EFFECT_MODE;
        cfg_data      = '0;
        item.valid    = 1'b0;
        item.opcode   = OP_TICK;
        item.red      = 8'd0;
        item.green    = 8'd0;
        item.blue     = 8'd0;
        send_idle_pct = 7;
        recv_idle_pct = 66;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset registers: long hold keeps the level dark
        send_refresh(color_t'{8'hFF, 8'hFF, 8'hFF});
        send_refresh(color_t'{8'h00, 8'h00, 8'h00});
        send_tick();

        // hold boundary, then a full breath in two refreshes
        program_effect(MODE_FIXED, 8'd255, 8'd255, 16'd3);
        send_refresh(color_t'{8'hFF, 8'hFF, 8'hFF});
        send_tick();
        send_refresh(color_t'{8'h01, 8'h80, 8'hFE});
        send_tick();
        send_refresh(color_t'{8'hFF, 8'h00, 8'h80});
        send_refresh(color_t'{8'hFF, 8'h01, 8'h80});
        send_refresh(color_t'{8'hFF, 8'hFF, 8'hFF});

        // rainbow with zero hold: falling step overshoots zero, wheel moves a whole segment
        program_effect(MODE_RAINBOW, 8'd128, 8'd255, 16'd0);
        repeat (8) send_refresh(random_color());
        send_tick();

        program_effect(MODE_FIXED, 8'd0, 8'd0, 16'd0);
        random_batch(BATCH_ITEMS);
        program_effect(MODE_RAINBOW, 8'd255, 8'd255, 16'd0);
        random_batch(BATCH_ITEMS);

        quiesce();
        send_idle_pct = 66;
        recv_idle_pct = 7;
        program_effect(MODE_RAINBOW, 8'd37, 8'd0, 16'd3);
        random_batch(BATCH_ITEMS);
        program_effect(MODE_FIXED, 8'd200, 8'd1, 16'd5);
        random_batch(BATCH_ITEMS);
        program_random_effect();
        random_batch(BATCH_ITEMS);

        quiesce();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        program_effect(MODE_RAINBOW, 8'd128, 8'd200, 16'd1);
        random_batch(BATCH_ITEMS);
        program_random_effect();
        random_batch(BATCH_ITEMS);
        program_random_effect();
        random_batch(BATCH_ITEMS);

        // long hold: the breath starts only once the counter reaches the hold time
        program_effect(MODE_FIXED, 8'd255, 8'd1, 16'd200);
        repeat (3) send_refresh(random_color());
        repeat (199) send_tick();
        send_refresh(color_t'{8'hFF, 8'hFF, 8'hFF});
        repeat (2) send_tick();
        repeat (3) send_refresh(color_t'{8'hFF, 8'h7F, 8'h01});

        quiesce();
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: sim.f
rtl/bre_pkg.sv
rtl/bre_ifs.sv
rtl/bre_lane.sv
rtl/bre_ctrl.sv
rtl/breathe_rainbow_engine_top.sv
test/breath_checker.sv
test/testbench.sv
